// ===== rtl/kcl_pkg.sv =====
package kcl_pkg;

    localparam int MAX_LEN = 8;
    localparam int FACTORY_LEN = 6;

    typedef logic [4:0] t_digit;
    typedef t_digit [MAX_LEN-1:0] t_code;

    localparam logic [29:0] FACTORY_RESET = 30'd206702624;
    localparam logic [39:0] ADMIN_RESET = 40'd318034282528;

    localparam t_digit KEY_ENTER = 5'd13;
    localparam t_digit KEY_DELETE = 5'd14;
    localparam t_digit KEY_OPEN = 5'd7;
    localparam t_digit KEY_MODIFY = 5'd3;
    localparam t_digit KEY_ADMIN = 5'd11;

    localparam logic CFG_FACTORY = 1'b0;
    localparam logic CFG_ADMIN = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_OPEN = 3'd1,
        MODE_OLD = 3'd2,
        MODE_NEW = 3'd3,
        MODE_ADMIN = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        EV_IGNORED = 4'd0,
        EV_STORED = 4'd1,
        EV_REJECTED = 4'd2,
        EV_RESTARTED = 4'd3,
        EV_STARTED = 4'd4,
        EV_ABORTED = 4'd5,
        EV_UNLOCK = 4'd6,
        EV_VERIFIED = 4'd7,
        EV_UPDATED = 4'd8,
        EV_RESET_DONE = 4'd9,
        EV_FAILURE = 4'd10,
        EV_LOCKED = 4'd11
    } t_event;

    typedef struct packed {
        t_mode mode;
        logic [3:0] count;
        logic [1:0] fail;
    } t_state;

    typedef struct packed {
        t_state next;
        logic wr_digit;
        logic store_user;
        logic restore_user;
        t_event event_res;
    } t_update;

    function automatic t_code factory_restore(input logic [29:0] factory);
        t_code code;
        code = t_code'({10'd0, factory});
        return code;
    endfunction

endpackage

// ===== rtl/kcl_step.sv =====
module kcl_step #(
    parameter int USER_LEN = 6,
    parameter int ADMIN_LEN = 8
) (
    input  kcl_pkg::t_digit i_key,
    input  kcl_pkg::t_state i_state,
    input  kcl_pkg::t_code  i_digits,
    input  kcl_pkg::t_code  i_user,
    input  kcl_pkg::t_code  i_admin,
    output kcl_pkg::t_update o_update
);

    localparam logic [3:0] ULEN = 4'(USER_LEN);
    localparam logic [3:0] ALEN = 4'(ADMIN_LEN);

    logic user_ok;
    logic admin_ok;
    logic verify_ok;
    logic [3:0] len;
    logic [1:0] fail_inc;
    logic is_switch;
    kcl_pkg::t_mode switch_mode;

    always_comb begin
        user_ok = 1'b1;
        admin_ok = 1'b1;
        for (int i = 0; i < kcl_pkg::MAX_LEN; i++) begin
            if (i < USER_LEN && i_digits[i] != i_user[i]) begin
                user_ok = 1'b0;
            end
            if (i < ADMIN_LEN && i_digits[i] != i_admin[i]) begin
                admin_ok = 1'b0;
            end
        end
    end

    assign len = (i_state.mode == kcl_pkg::MODE_ADMIN) ? ALEN : ULEN;
    assign verify_ok = (i_state.mode == kcl_pkg::MODE_ADMIN) ? admin_ok : user_ok;
    assign fail_inc = i_state.fail + 2'd1;
    assign is_switch = (i_key == kcl_pkg::KEY_OPEN) || (i_key == kcl_pkg::KEY_MODIFY)
                    || (i_key == kcl_pkg::KEY_ADMIN);

    always_comb begin
        priority if (i_key == kcl_pkg::KEY_OPEN) begin
            switch_mode = kcl_pkg::MODE_OPEN;
        end else if (i_key == kcl_pkg::KEY_MODIFY) begin
            switch_mode = kcl_pkg::MODE_OLD;
        end else begin
            switch_mode = kcl_pkg::MODE_ADMIN;
        end
    end

    always_comb begin
        o_update = '0;
        o_update.next = i_state;
        o_update.event_res = kcl_pkg::EV_IGNORED;
        unique case (i_state.mode)
            kcl_pkg::MODE_OPEN, kcl_pkg::MODE_OLD, kcl_pkg::MODE_NEW,
            kcl_pkg::MODE_ADMIN: begin
                priority if (is_switch) begin
                    o_update.next.mode = switch_mode;
                    o_update.next.count = 4'd0;
                    o_update.event_res = kcl_pkg::EV_STARTED;
                end else if (i_key == kcl_pkg::KEY_DELETE) begin
                    o_update.next.count = 4'd0;
                    o_update.event_res = kcl_pkg::EV_RESTARTED;
                end else if (i_key == kcl_pkg::KEY_ENTER) begin
                    o_update.next.count = 4'd0;
                    o_update.next.mode = kcl_pkg::MODE_IDLE;
                    priority if (i_state.count != len) begin
                        o_update.event_res = kcl_pkg::EV_ABORTED;
                    end else if (i_state.mode == kcl_pkg::MODE_NEW) begin
                        o_update.store_user = 1'b1;
                        o_update.event_res = kcl_pkg::EV_UPDATED;
                    end else if (!verify_ok) begin
                        o_update.next.fail = fail_inc;
                        o_update.event_res = (fail_inc == 2'd3) ? kcl_pkg::EV_LOCKED
                                                                : kcl_pkg::EV_FAILURE;
                    end else begin
                        o_update.next.fail = 2'd0;
                        priority if (i_state.mode == kcl_pkg::MODE_OPEN) begin
                            o_update.event_res = kcl_pkg::EV_UNLOCK;
                        end else if (i_state.mode == kcl_pkg::MODE_OLD) begin
                            o_update.next.mode = kcl_pkg::MODE_NEW;
                            o_update.event_res = kcl_pkg::EV_VERIFIED;
                        end else begin
                            o_update.restore_user = 1'b1;
                            o_update.event_res = kcl_pkg::EV_RESET_DONE;
                        end
                    end
                end else if (i_state.count < len) begin
                    o_update.wr_digit = 1'b1;
                    o_update.next.count = i_state.count + 4'd1;
                    o_update.event_res = kcl_pkg::EV_STORED;
                end else begin
                    o_update.event_res = kcl_pkg::EV_REJECTED;
                end
            end
            default: begin
                o_update.next.mode = kcl_pkg::MODE_IDLE;
                o_update.next.count = 4'd0;
                if (is_switch) begin
                    o_update.next.mode = switch_mode;
                    o_update.event_res = kcl_pkg::EV_STARTED;
                end
            end
        endcase
    end

endmodule

// ===== rtl/keypad_code_lock_controller_unit.sv =====
// A key is held in the input register, then its result in the result register.
// Throughput: one key per cycle unless the result stalls; the input register and
// result register are parted by the step logic; a key waits on a held result.
// Reset (i_rst_n low, synchronous): mode idle, entry count and fail count zero,
// user code restored from the factory code, configuration at reset values.
module keypad_code_lock_controller_unit #(
    parameter int USER_LEN = 6,
    parameter int ADMIN_LEN = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [4:0]  i_key_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_res,
    output logic [2:0]  o_mode,
    output logic [3:0]  o_digits_entered,
    output logic [1:0]  o_fail_total,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [39:0] i_cfg_data
);

    logic [29:0] r_factory_code;
    logic [39:0] r_admin_code;
    logic r_in_valid;
    kcl_pkg::t_digit r_key;
    kcl_pkg::t_state r_state;
    kcl_pkg::t_code r_digits;
    kcl_pkg::t_code r_user;
    logic r_out_valid;
    kcl_pkg::t_event r_event;
    kcl_pkg::t_state r_out_state;

    logic advance;
    logic in_take;
    kcl_pkg::t_update step;
    kcl_pkg::t_code n_user;

    assign advance = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take = i_in_valid && !o_in_stall;

    kcl_step #(
        .USER_LEN (USER_LEN),
        .ADMIN_LEN(ADMIN_LEN)
    ) u_step (
        .i_key   (r_key),
        .i_state (r_state),
        .i_digits(r_digits),
        .i_user  (r_user),
        .i_admin (kcl_pkg::t_code'(r_admin_code)),
        .o_update(step)
    );

    always_comb begin
        n_user = r_user;
        if (step.restore_user) begin
            n_user = kcl_pkg::factory_restore(r_factory_code);
        end else if (step.store_user) begin
            for (int i = 0; i < kcl_pkg::MAX_LEN; i++) begin
                if (i < USER_LEN) begin
                    n_user[i] = r_digits[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factory_code <= kcl_pkg::FACTORY_RESET;
            r_admin_code <= kcl_pkg::ADMIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kcl_pkg::CFG_FACTORY: r_factory_code <= i_cfg_data[29:0];
                kcl_pkg::CFG_ADMIN: r_admin_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_key <= i_key_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step.wr_digit) begin
            r_digits[r_state.count[2:0]] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode <= kcl_pkg::MODE_IDLE;
            r_state.count <= 4'd0;
            r_state.fail <= 2'd0;
            r_user <= kcl_pkg::factory_restore(kcl_pkg::FACTORY_RESET);
        end else if (advance) begin
            r_state <= step.next;
            r_user <= n_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_event <= step.event_res;
            r_out_state <= step.next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event;
    assign o_mode = r_out_state.mode;
    assign o_digits_entered = r_out_state.count;
    assign o_fail_total = r_out_state.fail;

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_mode == kcl_pkg::MODE_IDLE) |-> o_digits_entered == 4'd0)
        else $error("idle result with nonzero digit count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= 4'(kcl_pkg::MAX_LEN))
        else $error("entry count exceeds buffer depth");

    a_locked_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == kcl_pkg::EV_LOCKED) |-> o_fail_total == 2'd3)
        else $error("locked reported without full fail count");

    a_verified_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == kcl_pkg::EV_VERIFIED)
        |-> (o_mode == kcl_pkg::MODE_NEW) && (o_fail_total == 2'd0))
        else $error("verified result not in new-code mode");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_key))
        else $error("held key transaction lost");
`endif

endmodule
